@@ rtl/vig95_pkg.sv @@
// Shared definitions for the 95-symbol Vigenere encryptor.
// Holds the symbol code tables, field widths and the control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vig95_pkg;

    localparam int CHAR_W     = 7;    // ASCII character and symbol code width
    localparam int SLOT_W     = 6;    // key_slot field width
    localparam int CFG_W      = 7;    // key_length register width
    localparam int KEY_MAX_DEF = 64;
    localparam int ALPHA_MOD  = 95;

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    // Per-transfer control from the top level to the key position tracker
    typedef struct packed {
        logic load_key;   // key symbol written: position goes back to 0
        logic encrypt;    // data character taken: position advances
    } t_xfer_ctl;

    // ASCII character -> symbol code (0 when not in the alphabet).
    // '*' has two symbols (71 and 91) and codes to 91. Space is 95.
    function automatic logic [CHAR_W-1:0] char_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] code;
        case (c) inside
            [7'd65:7'd90]:  code = c - 7'd64;   // A-Z -> 1..26
            [7'd97:7'd122]: code = c - 7'd70;   // a-z -> 27..52
            [7'd49:7'd57]:  code = c + 7'd4;    // 1-9 -> 53..61
            7'd96:  code = 7'd62;   // `
            7'd126: code = 7'd63;   // ~
            7'd33:  code = 7'd64;   // !
            7'd64:  code = 7'd65;   // @
            7'd35:  code = 7'd66;   // #
            7'd36:  code = 7'd67;   // $
            7'd37:  code = 7'd68;   // %
            7'd94:  code = 7'd69;   // ^
            7'd38:  code = 7'd70;   // &
            7'd40:  code = 7'd72;   // (
            7'd41:  code = 7'd73;   // )
            7'd91:  code = 7'd74;   // [
            7'd93:  code = 7'd75;   // ]
            7'd123: code = 7'd76;   // {
            7'd125: code = 7'd77;   // }
            7'd92:  code = 7'd78;   // backslash
            7'd124: code = 7'd79;   // |
            7'd59:  code = 7'd80;   // ;
            7'd58:  code = 7'd81;   // :
            7'd39:  code = 7'd82;   // '
            7'd34:  code = 7'd83;   // "
            7'd44:  code = 7'd84;   // ,
            7'd46:  code = 7'd85;   // .
            7'd60:  code = 7'd86;   // <
            7'd62:  code = 7'd87;   // >
            7'd63:  code = 7'd88;   // ?
            7'd43:  code = 7'd89;   // +
            7'd45:  code = 7'd90;   // -
            7'd42:  code = 7'd91;   // *
            7'd47:  code = 7'd92;   // /
            7'd61:  code = 7'd93;   // =
            7'd95:  code = 7'd94;   // _
            7'd32:  code = 7'd95;   // space
            default: code = 7'd0;
        endcase
        return code;
    endfunction

    // Symbol 0..94 -> ASCII character. Symbol 0 is a space.
    function automatic logic [CHAR_W-1:0] sym_char(input logic [CHAR_W-1:0] s);
        logic [CHAR_W-1:0] ch;
        case (s) inside
            [7'd1:7'd26]:  ch = s + 7'd64;
            [7'd27:7'd52]: ch = s + 7'd70;
            [7'd53:7'd61]: ch = s - 7'd4;
            7'd62: ch = 7'd96;
            7'd63: ch = 7'd126;
            7'd64: ch = 7'd33;
            7'd65: ch = 7'd64;
            7'd66: ch = 7'd35;
            7'd67: ch = 7'd36;
            7'd68: ch = 7'd37;
            7'd69: ch = 7'd94;
            7'd70: ch = 7'd38;
            7'd71: ch = 7'd42;
            7'd72: ch = 7'd40;
            7'd73: ch = 7'd41;
            7'd74: ch = 7'd91;
            7'd75: ch = 7'd93;
            7'd76: ch = 7'd123;
            7'd77: ch = 7'd125;
            7'd78: ch = 7'd92;
            7'd79: ch = 7'd124;
            7'd80: ch = 7'd59;
            7'd81: ch = 7'd58;
            7'd82: ch = 7'd39;
            7'd83: ch = 7'd34;
            7'd84: ch = 7'd44;
            7'd85: ch = 7'd46;
            7'd86: ch = 7'd60;
            7'd87: ch = 7'd62;
            7'd88: ch = 7'd63;
            7'd89: ch = 7'd43;
            7'd90: ch = 7'd45;
            7'd91: ch = 7'd42;
            7'd92: ch = 7'd47;
            7'd93: ch = 7'd61;
            7'd94: ch = 7'd95;
            default: ch = 7'd32;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ rtl/vig95_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read data holds when no read is enabled. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vig95_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/vig95_keypos.sv @@
// Key position tracker: clamps the configured key length, picks the key
// entry for the current data character and advances/wraps the position.
// Depends on vig95_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vig95_keypos #(
    parameter int KEY_MAX = vig95_pkg::KEY_MAX_DEF,
    localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1,
    localparam int LEN_W = ($clog2(KEY_MAX + 1) > vig95_pkg::CFG_W) ?
                           $clog2(KEY_MAX + 1) : vig95_pkg::CFG_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire vig95_pkg::t_xfer_ctl        i_ctl,
    input  wire logic [vig95_pkg::CFG_W-1:0] i_key_length,
    output logic      [POS_W-1:0]            o_rd_addr,
    output logic      [POS_W-1:0]            o_pos
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [LEN_W-1:0] len_cfg;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] pos_eff;
    logic [LEN_W-1:0] pos_inc;

    always_comb begin
        len_cfg = LEN_W'(i_key_length);
        if (len_cfg == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_cfg > LEN_W'(KEY_MAX)) begin
            len_eff = LEN_W'(KEY_MAX);
        end else begin
            len_eff = len_cfg;
        end

        // a position left past a shortened key restarts at entry 0
        pos_ext = LEN_W'(r_pos);
        pos_eff = (pos_ext >= len_eff) ? '0 : pos_ext;
        pos_inc = pos_eff + LEN_W'(1);

        if (i_ctl.load_key) begin
            n_pos = '0;
        end else if (i_ctl.encrypt) begin
            n_pos = (pos_inc >= len_eff) ? '0 : POS_W'(pos_inc);
        end else begin
            n_pos = r_pos;
        end
    end

    assign o_rd_addr = POS_W'(pos_eff);
    assign o_pos     = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vig95_encode.sv @@
// Output stage: adds data and key codes mod 95, maps the symbol back to
// ASCII and holds it in the result register. Depends on vig95_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vig95_encode (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s1_valid,
    input  wire logic [vig95_pkg::CHAR_W-1:0] i_data_code,
    input  wire logic [vig95_pkg::CHAR_W-1:0] i_key_code,
    input  wire logic                         i_out_stall,
    output logic                              o_s1_take,
    output logic                              o_out_valid,
    output logic      [vig95_pkg::CHAR_W-1:0] o_out_char
);

    localparam int SUM_W = vig95_pkg::CHAR_W + 1;
    localparam logic [SUM_W-1:0] MOD = SUM_W'(vig95_pkg::ALPHA_MOD);

    logic                         r_out_valid;
    logic [vig95_pkg::CHAR_W-1:0] r_out_char;
    logic                         load;
    logic [SUM_W-1:0]             sum;
    logic [SUM_W-1:0]             red1;
    logic [SUM_W-1:0]             red2;
    logic [vig95_pkg::CHAR_W-1:0] n_out_char;

    // codes are at most 95 each, so the sum stays below 2*95+1
    always_comb begin
        sum  = SUM_W'(i_data_code) + SUM_W'(i_key_code);
        red1 = (sum >= MOD) ? sum - MOD : sum;
        red2 = (red1 >= MOD) ? red1 - MOD : red1;
        n_out_char = vig95_pkg::sym_char(red2[vig95_pkg::CHAR_W-1:0]);
    end

    assign load      = !r_out_valid || !i_out_stall;
    assign o_s1_take = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_s1_valid) begin
            r_out_char <= n_out_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;

endmodule

`default_nettype wire

@@ rtl/vig95_keystore_ram_note.sv @@
// Input stage register: symbol code of the accepted data character and its
// valid flag, held until the output stage takes it.
// Depends on vig95_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vig95_s1reg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic                         i_take,
    input  wire logic [vig95_pkg::CHAR_W-1:0] i_in_char,
    output logic                              o_valid,
    output logic      [vig95_pkg::CHAR_W-1:0] o_code
);

    logic                         r_valid;
    logic [vig95_pkg::CHAR_W-1:0] r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // data character is coded on the way in
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= vig95_pkg::char_code(i_in_char);
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;

endmodule

`default_nettype wire

@@ rtl/vigenere_95_symbol_encryptor_unit.sv @@
// Vigenere encryptor over a 95-symbol printable alphabet. One item per cycle
// while o_in_stall is low: a mode 0 transfer writes a key symbol and rewinds the
// key position, a mode 1 transfer encrypts one character. The transfer edge
// captures the character code and the key store read; the mod-95 add and symbol
// lookup then go into the output register once it is free or unstalled.
// Back-to-back items stream at one per cycle while i_out_stall is low, the only
// loop being the key position register. Key length is written through
// i_cfg_wr_en/i_cfg_wr_data; the user must write it while the block is idle, as
// the block itself does not enforce this. Depends on vig95_pkg, vig95_ram, vig95_keypos, vig95_s1reg and vig95_encode.
`timescale 1ns / 1ps
`default_nettype none

module vigenere_95_symbol_encryptor_unit #(
    parameter int KEY_MAX = vig95_pkg::KEY_MAX_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [vig95_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_mode,
    input  wire logic [vig95_pkg::SLOT_W-1:0] i_key_slot,
    input  wire logic [vig95_pkg::CHAR_W-1:0] i_in_char,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [vig95_pkg::CHAR_W-1:0] o_out_char
);

    localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LEN_W = ($clog2(KEY_MAX + 1) > vig95_pkg::CFG_W) ?
                           $clog2(KEY_MAX + 1) : vig95_pkg::CFG_W;

    logic [vig95_pkg::CFG_W-1:0]  r_key_length;
    logic                         accept;
    logic                         s1_load;
    logic                         s1_take;
    logic                         s1_valid;
    logic [vig95_pkg::CHAR_W-1:0] s1_code;
    logic [vig95_pkg::CHAR_W-1:0] key_code;
    logic                         ram_wr_en;
    logic [POS_W-1:0]             rd_addr;
    logic [POS_W-1:0]             pos;
    vig95_pkg::t_xfer_ctl         xfer_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= vig95_pkg::CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            r_key_length <= i_cfg_wr_data;
        end
    end

    assign o_in_stall = s1_valid && !s1_take;
    assign accept     = i_in_valid && !o_in_stall;
    assign s1_load    = accept && (i_mode == vig95_pkg::MODE_DATA);

    // slots beyond the store leave it untouched but still rewind the position
    assign ram_wr_en = accept && (i_mode == vig95_pkg::MODE_KEY) &&
                       (LEN_W'(i_key_slot) < LEN_W'(KEY_MAX));

    assign xfer_ctl.load_key = accept && (i_mode == vig95_pkg::MODE_KEY);
    assign xfer_ctl.encrypt  = s1_load;

    vig95_keypos #(
        .KEY_MAX (KEY_MAX)
    ) u_keypos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (xfer_ctl),
        .i_key_length (r_key_length),
        .o_rd_addr    (rd_addr),
        .o_pos        (pos)
    );

    vig95_ram #(
        .WIDTH (vig95_pkg::CHAR_W),
        .DEPTH (KEY_MAX)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (POS_W'(i_key_slot)),
        .i_wr_data (vig95_pkg::char_code(i_in_char)),
        .i_rd_en   (s1_load),
        .i_rd_addr (rd_addr),
        .o_rd_data (key_code)
    );

    vig95_s1reg u_s1reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (s1_load),
        .i_take    (s1_take),
        .i_in_char (i_in_char),
        .o_valid   (s1_valid),
        .o_code    (s1_code)
    );

    vig95_encode u_encode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_data_code (s1_code),
        .i_key_code  (key_code),
        .i_out_stall (i_out_stall),
        .o_s1_take   (s1_take),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char)
    );

    // key position never leaves the store
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(pos) < LEN_W'(KEY_MAX))
        else $error("key position out of range");

    // an encrypted character always lands in the middle stage
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_load |=> s1_valid)
        else $error("data transfer lost before output stage");

    // a blocked middle stage keeps its character code
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !s1_take) |=> (s1_valid && $stable(s1_code)))
        else $error("middle stage changed while blocked");

    // results are always printable ASCII
    a_out_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_char >= 7'd32 && o_out_char <= 7'd126))
        else $error("non-printable result");

endmodule

`default_nettype wire
